FILE: rtl/lags_pkg.sv
// Shared types and constants for the bounded Life grid block.
// No dependencies; every other file imports this package.
package lags_pkg;

  // Payload widths fixed by the channel definitions
  localparam int REQ_W     = 2;
  localparam int COORD_W   = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  // Width for size compares; covers every supported grid dimension (up to 511)
  localparam int CMP_W     = 9;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TOGGLE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_W-1:0]     CFG_SIZE_RESET  = 7'd64;
  localparam logic [CFG_W-1:0]     CFG_SIZE_MIN    = 7'd2;

  // B3/S23 neighbor counts
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] KEEP_COUNT  = 4'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_RES,
    ST_ADV_START,
    ST_ADV_FIRST,
    ST_ADV_ROW
  } lags_state_t;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;  // controller can take a request
    logic rd_cell;   // read the row holding the addressed cell
    logic rd_row;    // read the next row of the sweep
    logic take_cur;  // first row of the sweep arrives
    logic step_row;  // write one new row and shift the window
    logic finish;    // load the result, commit a toggle
  } lags_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;  // a request is offered
    logic in_adv;    // offered request is an advance
    logic wr_last;   // sweep is on the last active row
    logic out_free;  // result register can take a value
  } lags_sts_t;

endpackage

FILE: rtl/lags_if.sv
// Channel interfaces: request, result and configuration write.
// Depends on lags_pkg for payload widths.
interface lags_req_if import lags_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [COORD_W-1:0] cell_x;
  logic [COORD_W-1:0] cell_y;

  modport source (output valid, req_type, cell_x, cell_y, input ready);
  modport sink   (input valid, req_type, cell_x, cell_y, output ready);
endinterface

interface lags_res_if import lags_pkg::*; ();
  logic valid;
  logic ready;
  logic cell_state;
  logic out_of_range;

  modport source (output valid, cell_state, out_of_range, input ready);
  modport sink   (input valid, cell_state, out_of_range, output ready);
endinterface

interface lags_cfg_if import lags_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_W-1:0]     wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

FILE: rtl/lags_row_rule.sv
// Row-wide B3/S23 next-generation logic for one grid row.
// Depends on lags_pkg for the rule counts.
module lags_row_rule import lags_pkg::*; #(
  parameter int MAX_WIDTH = 64
) (
  input  logic [MAX_WIDTH-1:0] col_mask,
  input  logic [MAX_WIDTH-1:0] above,
  input  logic [MAX_WIDTH-1:0] mid,
  input  logic [MAX_WIDTH-1:0] below,
  output logic [MAX_WIDTH-1:0] next_row
);

  // Rows padded with a dead cell on each side; inactive columns count as dead
  logic [MAX_WIDTH+1:0] pa, pm, pb;
  assign pa = {1'b0, above & col_mask, 1'b0};
  assign pm = {1'b0, mid & col_mask, 1'b0};
  assign pb = {1'b0, below & col_mask, 1'b0};

  // Per-column neighbor count and rule; inactive columns keep their value
  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_col
    logic [3:0] n;
    logic       alive;
    assign n = 4'(pa[i]) + 4'(pa[i+1]) + 4'(pa[i+2]) + 4'(pm[i]) + 4'(pm[i+2])
             + 4'(pb[i]) + 4'(pb[i+1]) + 4'(pb[i+2]);
    assign alive = (n == BIRTH_COUNT) || (pm[i+1] && (n == KEEP_COUNT));
    assign next_row[i] = col_mask[i] ? alive : mid[i];
  end

endmodule

FILE: rtl/lags_ctrl.sv
// Sequencer for requests: cell access and the row-by-row advance sweep.
// Depends on lags_pkg for the state, command and status types.
module lags_ctrl import lags_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  lags_sts_t   sts,
  output lags_cmd_t   cmd
);

  lags_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          state_next = sts.in_adv ? ST_ADV_START : ST_CELL_RD;
        end
      end
      ST_CELL_RD: begin
        cmd.rd_cell = 1'b1;
        state_next  = ST_CELL_RES;
      end
      ST_CELL_RES: begin
        // hold read data until the result register frees up
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_ADV_START: begin
        cmd.rd_row = 1'b1;
        state_next = ST_ADV_FIRST;
      end
      ST_ADV_FIRST: begin
        cmd.take_cur = 1'b1;
        cmd.rd_row   = 1'b1;
        state_next   = ST_ADV_ROW;
      end
      ST_ADV_ROW: begin
        cmd.step_row = 1'b1;
        cmd.rd_row   = 1'b1;
        if (sts.wr_last) begin
          state_next = ST_CELL_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/lags_datapath.sv
// Grid storage, configuration registers, row window and result register.
// Depends on lags_pkg, the channel interfaces and lags_row_rule.
module lags_datapath import lags_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic          clk,
  input  logic          rst,
  lags_cfg_if.sink      cfg,
  lags_req_if.sink      req,
  lags_res_if.source    res,
  input  lags_cmd_t     cmd,
  output lags_sts_t     sts
);

  localparam int AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // Configuration registers
  logic [CFG_W-1:0] grid_width, grid_height;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= CFG_SIZE_RESET;
      grid_height <= CFG_SIZE_RESET;
    end else if (cfg.valid) begin
      if (cfg.reg_index == REG_GRID_WIDTH) begin
        grid_width <= cfg.wdata;
      end else if (cfg.reg_index == REG_GRID_HEIGHT) begin
        grid_height <= cfg.wdata;
      end
    end
  end

  // Active size, clamped to 2..MAX
  logic [CMP_W-1:0] w_act, h_act;

  always_comb begin
    if (grid_width < CFG_SIZE_MIN) begin
      w_act = CMP_W'(CFG_SIZE_MIN);
    end else if (CMP_W'(grid_width) > CMP_W'(MAX_WIDTH)) begin
      w_act = CMP_W'(MAX_WIDTH);
    end else begin
      w_act = CMP_W'(grid_width);
    end
    if (grid_height < CFG_SIZE_MIN) begin
      h_act = CMP_W'(CFG_SIZE_MIN);
    end else if (CMP_W'(grid_height) > CMP_W'(MAX_HEIGHT)) begin
      h_act = CMP_W'(MAX_HEIGHT);
    end else begin
      h_act = CMP_W'(grid_height);
    end
  end

  logic [MAX_WIDTH-1:0] col_mask;
  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_mask
    assign col_mask[i] = CMP_W'(i) < w_act;
  end

  // Request capture
  logic [REQ_W-1:0]   req_type;
  logic [COORD_W-1:0] cell_x, cell_y;
  logic               req_xfer;

  assign req.ready    = cmd.in_ready;
  assign req_xfer     = req.valid && cmd.in_ready;
  assign sts.in_valid = req.valid;
  assign sts.in_adv   = req.req_type == REQ_ADVANCE;

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      req_type <= req.req_type;
      cell_x   <= req.cell_x;
      cell_y   <= req.cell_y;
    end
  end

  logic [CMP_W-1:0] cx_ext, cy_ext;
  logic [XW-1:0]    cx_idx;
  logic [AW-1:0]    cy_addr;
  logic             in_grid;

  assign cx_ext  = CMP_W'(cell_x);
  assign cy_ext  = CMP_W'(cell_y);
  assign cx_idx  = cx_ext[XW-1:0];
  assign cy_addr = cy_ext[AW-1:0];
  assign in_grid = (cx_ext < w_act) && (cy_ext < h_act);

  // Sweep pointers
  logic [HW-1:0] rd_ptr, wr_ptr;
  logic          rd_more;

  assign rd_more     = CMP_W'(rd_ptr) < h_act;
  assign sts.wr_last = (CMP_W'(wr_ptr) + CMP_W'(1)) == h_act;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
    end else if (req_xfer) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
    end else begin
      if (cmd.rd_row && rd_more) begin
        rd_ptr <= rd_ptr + HW'(1);
      end
      if (cmd.step_row) begin
        wr_ptr <= wr_ptr + HW'(1);
      end
    end
  end

  // Grid memory with per-row valid bits; an unwritten row reads as dead
  logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];
  logic [MAX_HEIGHT-1:0] row_valid;
  logic [MAX_WIDTH-1:0] mem_q, rdata;
  logic                 vld_q;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [MAX_WIDTH-1:0] wr_data, new_row, flip_mask;
  logic                 do_toggle;

  assign rd_en   = cmd.rd_cell || (cmd.rd_row && rd_more);
  assign rd_addr = cmd.rd_cell ? cy_addr : rd_ptr[AW-1:0];

  assign flip_mask = MAX_WIDTH'(1) << cx_idx;
  assign do_toggle = cmd.finish && (req_type == REQ_TOGGLE) && in_grid;
  assign wr_en     = cmd.step_row || do_toggle;
  assign wr_addr   = cmd.step_row ? wr_ptr[AW-1:0] : cy_addr;
  assign wr_data   = cmd.step_row ? new_row : (rdata ^ flip_mask);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      vld_q     <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= row_valid[rd_addr];
      end
    end
  end

  assign rdata = vld_q ? mem_q : '0;

  // Row window: old copies of the row above and the row being updated
  logic [MAX_WIDTH-1:0] prev_row, cur_row, below_row;

  assign below_row = sts.wr_last ? '0 : rdata;

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      prev_row <= '0;
    end else if (cmd.step_row) begin
      prev_row <= cur_row;
    end
    if (cmd.take_cur || cmd.step_row) begin
      cur_row <= rdata;
    end
  end

  lags_row_rule #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_rule (
    .col_mask (col_mask),
    .above    (prev_row),
    .mid      (cur_row),
    .below    (below_row),
    .next_row (new_row)
  );

  // Result register
  logic out_valid, cell_bit;

  assign cell_bit     = rdata[cx_idx] ^ (req_type == REQ_TOGGLE);
  assign sts.out_free = !out_valid || res.ready;
  assign res.valid    = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res.cell_state   <= in_grid && cell_bit;
      res.out_of_range <= !in_grid;
    end
  end

endmodule

FILE: rtl/life_automaton_grid_step.sv
// Top level of the bounded B3/S23 Life grid block.
// Depends on lags_pkg, the channel interfaces, lags_ctrl and lags_datapath.
//
//   channel | dir | payload                          | transfer when
//   --------+-----+----------------------------------+------------------------
//   cfg     | in  | reg_index, wdata                 | cfg.valid & cfg.ready
//   req     | in  | req_type, cell_x, cell_y         | req.valid & req.ready
//   res     | out | cell_state, out_of_range         | res.valid & res.ready
//
// Toggle and read: after transfer the addressed row is read, then the result is loaded.
// Advance: the sweep reads one row ahead while each new row is written back, then the
// addressed row is read and the result loaded as for a read.
// A finished result waits in the output register while the next request is taken;
// the block stalls only if a second result is ready before it.
// Reset clears the grid at once through per-row valid bits; cfg is always ready.
module life_automaton_grid_step import lags_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  lags_cfg_if.sink    cfg,
  lags_req_if.sink    req,
  lags_res_if.source  res
);

  lags_cmd_t cmd;
  lags_sts_t sts;

  lags_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  lags_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .res (res),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Testbench for life_automaton_grid_step: directed and random requests against a
// cycle-free model of the bounded B3/S23 grid. Depends on lags_pkg, the lags_*_if
// channel interfaces and the block's RTL.
module tb;
  import lags_pkg::*;

  localparam int GRID_MAX    = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 8;
  // Spare request code; the block treats it as a read
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } cell_req_t;

  typedef struct packed {
    logic alive;
    logic off_grid;
  } cell_result_t;

  logic clk;
  logic rst;

  lags_cfg_if cfg_bus ();
  lags_req_if req_bus ();
  lags_res_if res_bus ();

  life_automaton_grid_step #(
    .MAX_WIDTH (GRID_MAX),
    .MAX_HEIGHT(GRID_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus),
    .req(req_bus),
    .res(res_bus)
  );

  // Model state: one row of cells per element, bit x is column x
  logic [GRID_MAX-1:0] life_rows [GRID_MAX];
  logic [CFG_W-1:0]    width_reg;
  logic [CFG_W-1:0]    height_reg;

  cell_req_t    request_queue [$];
  cell_result_t expected_cells [$];

  cell_req_t    next_req;
  cell_result_t want;
  int           burst_left;
  int           gap_left;
  logic [15:0]  stall_pat;
  logic [3:0]   stall_phase;
  int           quiet_cycles;
  int           mismatches;
  logic         sender_steady;
  logic         recv_steady;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------- model
  function automatic int active_size(logic [CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > GRID_MAX) return GRID_MAX;
    return int'(v);
  endfunction

  // One B3/S23 generation over the active area; cells beyond it are dead neighbors
  function automatic void step_generation(int w, int h);
    logic [GRID_MAX-1:0] old_rows [GRID_MAX];
    int xx, yy, dx, dy, nx, ny, n;
    old_rows = life_rows;
    for (yy = 0; yy < h; yy++) begin
      for (xx = 0; xx < w; xx++) begin
        n = 0;
        for (dy = -1; dy <= 1; dy++) begin
          for (dx = -1; dx <= 1; dx++) begin
            nx = xx + dx;
            ny = yy + dy;
            if ((dx != 0 || dy != 0) && nx >= 0 && nx < w && ny >= 0 && ny < h)
              n += old_rows[ny][nx];
          end
        end
        life_rows[yy][xx] = (n == 3) || (old_rows[yy][xx] && n == 2);
      end
    end
  endfunction

  function automatic cell_result_t predict_cell_result(cell_req_t r);
    int w, h;
    logic hit;
    cell_result_t res;
    w   = active_size(width_reg);
    h   = active_size(height_reg);
    hit = (r.x < w) && (r.y < h);
    if (r.kind == REQ_ADVANCE)
      step_generation(w, h);
    else if (r.kind == REQ_TOGGLE && hit)
      life_rows[r.y][r.x] = ~life_rows[r.y][r.x];
    res.alive    = hit ? life_rows[r.y][r.x] : 1'b0;
    res.off_grid = !hit;
    return res;
  endfunction

  // ---------------------------------------------------------------- request driver
  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (req_bus.valid && req_bus.ready)
        expected_cells.push_back(predict_cell_result(
          '{kind: req_bus.req_type, x: req_bus.cell_x, y: req_bus.cell_y}));
      if (!req_bus.valid || req_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_bus.valid <= 1'b0;
        end else if (request_queue.size() == 0) begin
          req_bus.valid <= 1'b0;
        end else begin
          next_req = request_queue.pop_front();
          req_bus.valid    <= 1'b1;
          req_bus.req_type <= next_req.kind;
          req_bus.cell_x   <= next_req.x;
          req_bus.cell_y   <= next_req.y;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = (sender_steady || $urandom_range(0, 3) == 0) ? 0
                                                                      : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- result monitor
  task automatic note_failure(string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
      stall_pat   = '1;
      stall_phase = '0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (expected_cells.size() == 0) begin
          note_failure($sformatf("unexpected result cell_state=%0b out_of_range=%0b",
                                 res_bus.cell_state, res_bus.out_of_range));
        end else begin
          want = expected_cells.pop_front();
          if (res_bus.cell_state !== want.alive || res_bus.out_of_range !== want.off_grid)
            note_failure($sformatf("cell_state exp %0b got %0b, out_of_range exp %0b got %0b",
                                   want.alive, res_bus.cell_state,
                                   want.off_grid, res_bus.out_of_range));
        end
      end
      // Stall pattern reloaded each time the 4-bit phase counter wraps, mostly ready
      if (stall_phase == 0)
        stall_pat = recv_steady ? 16'hFFFF
                  : ((($urandom_range(0, 2) == 0) ? 16'($urandom())
                                                  : 16'($urandom() | $urandom())) | 16'h1);
      res_bus.ready <= stall_pat[stall_phase];
      stall_phase = stall_phase + 1'b1;
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready) ||
                 (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers
  task automatic queue_request(logic [REQ_W-1:0] kind, int x, int y);
    request_queue.push_back('{kind: kind, x: COORD_W'(x), y: COORD_W'(y)});
  endtask

  // Wait until every request is accepted and answered; ends on a falling edge
  task automatic wait_idle();
    do @(negedge clk);
    while (request_queue.size() != 0 || req_bus.valid || expected_cells.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_size_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wdata     <= value;
    do @(posedge clk);
    while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == REG_GRID_WIDTH) width_reg = value;
    else height_reg = value;
  endtask

  task automatic set_grid_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    wait_idle();
    write_size_reg(REG_GRID_WIDTH, w);
    write_size_reg(REG_GRID_HEIGHT, h);
    @(negedge clk);
  endtask

  // Random soups seeded into the active area and stepped, mixed with loose requests
  task automatic fill_random(int count);
    int made, pick, w, h, x0, y0, span, dx, dy, g, gens;
    made = 0;
    w    = active_size(width_reg);
    h    = active_size(height_reg);
    while (made < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        x0   = $urandom_range(0, w - 1);
        y0   = $urandom_range(0, h - 1);
        span = $urandom_range(3, 5);
        for (dy = 0; dy < span; dy++)
          for (dx = 0; dx < span; dx++)
            if (x0 + dx < w && y0 + dy < h && $urandom_range(0, 1) == 1) begin
              queue_request(REQ_TOGGLE, x0 + dx, y0 + dy);
              made++;
            end
        gens = $urandom_range(1, 4);
        for (g = 0; g < gens; g++) begin
          queue_request(REQ_ADVANCE, x0 + $urandom_range(0, span - 1),
                        y0 + $urandom_range(0, span - 1));
          queue_request(REQ_READ, x0 + $urandom_range(0, span - 1),
                        y0 + $urandom_range(0, span - 1));
          made += 2;
        end
      end else begin
        pick = $urandom_range(0, 9);
        if ($urandom_range(0, 4) == 0) begin
          x0 = $urandom_range(0, GRID_MAX - 1);
          y0 = $urandom_range(0, GRID_MAX - 1);
        end else begin
          x0 = $urandom_range(0, w - 1);
          y0 = $urandom_range(0, h - 1);
        end
        if (pick < 4)      queue_request(REQ_TOGGLE, x0, y0);
        else if (pick < 6) queue_request(REQ_ADVANCE, x0, y0);
        else if (pick < 9) queue_request(REQ_READ, x0, y0);
        else               queue_request(REQ_SPARE, x0, y0);
        made++;
      end
    end
  endtask

  // ---------------------------------------------------------------- test sequence
  localparam logic [CFG_W-1:0] FIXED_W [4] = '{7'd2, 7'd127, 7'd0, 7'd64};
  localparam logic [CFG_W-1:0] FIXED_H [4] = '{7'd2, 7'd64, 7'd127, 7'd3};

  initial begin
    int phase;
    logic [CFG_W-1:0] wcfg, hcfg;

    rst               = 1'b1;
    req_bus.valid     = 1'b0;
    req_bus.req_type  = REQ_READ;
    req_bus.cell_x    = '0;
    req_bus.cell_y    = '0;
    res_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.reg_index = REG_GRID_WIDTH;
    cfg_bus.wdata     = CFG_SIZE_RESET;
    mismatches        = 0;
    sender_steady     = 1'b0;
    recv_steady       = 1'b0;
    width_reg         = CFG_SIZE_RESET;
    height_reg        = CFG_SIZE_RESET;
    foreach (life_rows[i]) life_rows[i] = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset size: block at the origin, lone cell in the far corner, a blinker
    queue_request(REQ_TOGGLE, 0, 0);
    queue_request(REQ_TOGGLE, 1, 0);
    queue_request(REQ_TOGGLE, 0, 1);
    queue_request(REQ_TOGGLE, 1, 1);
    queue_request(REQ_TOGGLE, 63, 63);
    queue_request(REQ_TOGGLE, 30, 31);
    queue_request(REQ_TOGGLE, 31, 31);
    queue_request(REQ_TOGGLE, 32, 31);
    queue_request(REQ_ADVANCE, 31, 30);
    queue_request(REQ_READ, 63, 63);
    queue_request(REQ_SPARE, 0, 0);
    queue_request(REQ_ADVANCE, 63, 63);
    queue_request(REQ_READ, 30, 31);

    // Width register below minimum, height above maximum
    set_grid_size(7'd0, 7'd127);
    queue_request(REQ_TOGGLE, 2, 5);
    queue_request(REQ_TOGGLE, 1, 63);
    queue_request(REQ_READ, 5, 5);
    queue_request(REQ_ADVANCE, 0, 0);
    queue_request(REQ_READ, 1, 63);

    // Two rows only; the blinker sits outside and must be left alone
    set_grid_size(7'd65, 7'd1);
    queue_request(REQ_READ, 31, 31);
    queue_request(REQ_ADVANCE, 63, 1);

    set_grid_size(7'd64, 7'd64);
    queue_request(REQ_READ, 31, 31);
    queue_request(REQ_READ, 31, 30);
    queue_request(REQ_TOGGLE, 63, 0);
    queue_request(REQ_READ, 63, 0);

    // Random phases; each one drains halfway so the sender sits out a full drain
    for (phase = 0; phase < 8; phase++) begin
      if (phase < 4) begin
        wcfg = FIXED_W[phase];
        hcfg = FIXED_H[phase];
      end else begin
        wcfg = CFG_W'($urandom_range(0, 127));
        hcfg = CFG_W'($urandom_range(0, 127));
      end
      set_grid_size(wcfg, hcfg);
      sender_steady = (phase == 1) || ($urandom_range(0, 3) == 0);
      recv_steady   = (phase == 1) || ($urandom_range(0, 3) == 0);
      fill_random(38);
      wait_idle();
      fill_random(38);
    end

    wait_idle();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && expected_cells.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/lags_pkg.sv
rtl/lags_if.sv
rtl/lags_row_rule.sv
rtl/lags_ctrl.sv
rtl/lags_datapath.sv
rtl/life_automaton_grid_step.sv
test/tb.sv
